[hdl/jsu_pkg.sv]
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_STR       = 3'd1,
        MODE_ESC       = 3'd2,
        MODE_HEX_FIRST = 3'd3,
        MODE_LOW_BSL   = 3'd4,
        MODE_LOW_U     = 3'd5,
        MODE_HEX_LOW   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // One input word's worth of results: up to four bytes, index of the final one.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        t_status         status;
    } t_grp;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIM = 8'h20;

    localparam logic [15:0] HI_FIRST = 16'hD800;
    localparam logic [15:0] HI_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_FIRST = 16'hDC00;
    localparam logic [15:0] LO_LAST  = 16'hDFFF;

    localparam logic [20:0] CP_MAX1 = 21'h00007F;
    localparam logic [20:0] CP_MAX2 = 21'h0007FF;
    localparam logic [20:0] CP_MAX3 = 21'h00FFFF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Simple escapes: {valid, decoded byte}
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        unique case (c)
            CH_QUOTE: r = {1'b1, CH_QUOTE};
            CH_BSL:   r = {1'b1, CH_BSL};
            CH_SLASH: r = {1'b1, CH_SLASH};
            8'h62:    r = {1'b1, 8'h08};
            8'h66:    r = {1'b1, 8'h0C};
            8'h6E:    r = {1'b1, 8'h0A};
            8'h72:    r = {1'b1, 8'h0D};
            8'h74:    r = {1'b1, 8'h09};
            default:  r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/jsu_if.sv]
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       input_end;

    modport source (output valid, output data_byte, output input_end, input ready);
    modport sink   (input valid, input data_byte, input input_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

[hdl/json_string_unescape_utf8.sv]
// Channel  Dir  Payload                         Handshake
// i_in     in   data_byte[7:0], input_end       valid/ready
// o_out    out  out_byte[7:0], status[1:0], last valid/ready
//
// One input word is taken per cycle while the result buffer has room.
// Each word is decoded in the cycle it is accepted into a group of 0..4
// result words, stored in a two-entry group buffer; o_out drains one word
// per cycle while o_out.ready is high; a word with n results goes out as n words.
// Reset (i_rst_n low, synchronous) empties the buffer and returns to idle.
// Stalls on o_out back up into the buffer and then drop i_in.ready.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic       fire, pop, push, pop_grp;
    t_grp       grp;
    t_grp       r_buf [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic [1:0] r_idx;
    t_grp       head;

    assign i_in.ready = (r_count != 2'd2);
    assign fire       = i_in.valid && i_in.ready;

    jsu_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_in.data_byte),
        .i_input_end (i_in.input_end),
        .o_push      (push),
        .o_grp       (grp)
    );

    // head group feeds the output straight from its register
    assign head           = r_buf[r_rd];
    assign o_out.valid    = (r_count != 2'd0);
    assign o_out.out_byte = head.bytes[r_idx];
    assign o_out.status   = head.status;
    assign o_out.last     = (r_idx == head.last_idx);

    assign pop     = o_out.valid && o_out.ready;
    assign pop_grp = pop && o_out.last;

    always_ff @(posedge i_clk) begin
        if (fire && push) begin
            r_buf[r_wr] <= grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
            r_idx   <= 2'd0;
        end else begin
            if (fire && push) begin
                r_wr <= ~r_wr;
            end
            if (pop_grp) begin
                r_rd  <= ~r_rd;
                r_idx <= 2'd0;
            end else if (pop) begin
                r_idx <= r_idx + 2'd1;
            end
            unique case ({fire && push, pop_grp})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // buffer never overfills
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("group buffer overflow");

    // done and error words always close their group
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_DATA) |-> (o_out.last && r_idx == 2'd0))
        else $error("terminal word not alone");

    // byte index stays inside the head group
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_idx <= head.last_idx))
        else $error("byte index past end of group");

    // an emptied buffer only refills through an accepted word
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 && !(fire && push)) |=> (r_count == 2'd0))
        else $error("buffer filled without input");

endmodule

[hdl/jsu_decode.sv]
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_input_end,
    output logic       o_push,
    output t_grp       o_grp
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_cu, n_cu;
    logic [9:0]  r_hs, n_hs;

    logic [4:0]  dig;
    logic [8:0]  esc;
    logic [15:0] cu_shift;
    logic        hex_full, is_hi, is_lo;
    logic [20:0] cp;
    logic [3:0][7:0] u_bytes;
    logic [1:0]  u_last;

    assign dig      = hex_digit(i_data_byte);
    assign esc      = esc_map(i_data_byte);
    assign cu_shift = {r_cu[11:0], dig[3:0]};
    assign hex_full = (r_hex == 2'd3);
    assign is_hi    = (cu_shift >= HI_FIRST) && (cu_shift <= HI_LAST);
    assign is_lo    = (cu_shift >= LO_FIRST) && (cu_shift <= LO_LAST);

    // pair: 0x10000 + (hs << 10) + (lo - 0xdc00)
    assign cp = (r_mode == MODE_HEX_LOW) ? {{1'b0, r_hs} + 11'd64, cu_shift[9:0]}
                                         : {5'd0, cu_shift};

    always_comb begin
        u_bytes = '0;
        if (cp <= CP_MAX1) begin
            u_bytes[0] = cp[7:0];
            u_last     = 2'd0;
        end else if (cp <= CP_MAX2) begin
            u_bytes[0] = LEAD2 | {3'd0, cp[10:6]};
            u_bytes[1] = CONT | {2'd0, cp[5:0]};
            u_last     = 2'd1;
        end else if (cp <= CP_MAX3) begin
            u_bytes[0] = LEAD3 | {4'd0, cp[15:12]};
            u_bytes[1] = CONT | {2'd0, cp[11:6]};
            u_bytes[2] = CONT | {2'd0, cp[5:0]};
            u_last     = 2'd2;
        end else begin
            u_bytes[0] = LEAD4 | {5'd0, cp[20:18]};
            u_bytes[1] = CONT | {2'd0, cp[17:12]};
            u_bytes[2] = CONT | {2'd0, cp[11:6]};
            u_bytes[3] = CONT | {2'd0, cp[5:0]};
            u_last     = 2'd3;
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_cu   = r_cu;
        n_hs   = r_hs;
        if (i_input_end) begin
            n_mode = MODE_IDLE;
            n_hex  = '0;
            n_cu   = '0;
            n_hs   = '0;
        end else begin
            unique case (r_mode)
                MODE_STR: begin
                    if (i_data_byte == CH_QUOTE || i_data_byte < CTRL_LIM) begin
                        n_mode = MODE_IDLE; n_hex = '0; n_cu = '0; n_hs = '0;
                    end else if (i_data_byte == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    if (esc[8]) begin
                        n_mode = MODE_STR;
                    end else if (i_data_byte == CH_U) begin
                        n_mode = MODE_HEX_FIRST; n_hex = '0; n_cu = '0;
                    end else begin
                        n_mode = MODE_IDLE; n_hex = '0; n_cu = '0; n_hs = '0;
                    end
                end
                MODE_HEX_FIRST, MODE_HEX_LOW: begin
                    if (!dig[4]) begin
                        n_mode = MODE_IDLE; n_hex = '0; n_cu = '0; n_hs = '0;
                    end else if (!hex_full) begin
                        n_hex = r_hex + 2'd1;
                        n_cu  = cu_shift;
                    end else if (r_mode == MODE_HEX_FIRST && is_hi) begin
                        n_hs = cu_shift[9:0];
                        n_cu = '0; n_hex = '0; n_mode = MODE_LOW_BSL;
                    end else if (r_mode == MODE_HEX_FIRST ? is_lo : !is_lo) begin
                        n_mode = MODE_IDLE; n_hex = '0; n_cu = '0; n_hs = '0;
                    end else begin
                        n_mode = MODE_STR; n_hex = '0; n_cu = '0;
                        if (r_mode == MODE_HEX_LOW) begin
                            n_hs = '0;
                        end
                    end
                end
                MODE_LOW_BSL: begin
                    if (i_data_byte == CH_BSL) begin
                        n_mode = MODE_LOW_U;
                    end else begin
                        n_mode = MODE_IDLE; n_hex = '0; n_cu = '0; n_hs = '0;
                    end
                end
                MODE_LOW_U: begin
                    if (i_data_byte == CH_U) begin
                        n_mode = MODE_HEX_LOW; n_hex = '0; n_cu = '0;
                    end else begin
                        n_mode = MODE_IDLE; n_hex = '0; n_cu = '0; n_hs = '0;
                    end
                end
                default: begin
                    n_hex = '0; n_cu = '0; n_hs = '0;
                    n_mode = (i_data_byte == CH_QUOTE) ? MODE_STR : MODE_IDLE;
                end
            endcase
        end
    end

    // results of this word
    always_comb begin
        o_push         = 1'b0;
        o_grp.bytes    = '0;
        o_grp.last_idx = 2'd0;
        o_grp.status   = ST_DATA;
        if (i_input_end) begin
            o_push       = (r_mode != MODE_IDLE);
            o_grp.status = ST_BAD;
        end else begin
            unique case (r_mode)
                MODE_STR: begin
                    o_push = (i_data_byte != CH_BSL);
                    if (i_data_byte == CH_QUOTE) begin
                        o_grp.status = ST_DONE;
                    end else if (i_data_byte < CTRL_LIM) begin
                        o_grp.status = ST_BAD;
                    end else begin
                        o_grp.bytes[0] = i_data_byte;
                    end
                end
                MODE_ESC: begin
                    o_push = (i_data_byte != CH_U);
                    if (esc[8]) begin
                        o_grp.bytes[0] = esc[7:0];
                    end else begin
                        o_grp.status = ST_BAD;
                    end
                end
                MODE_HEX_FIRST, MODE_HEX_LOW: begin
                    if (!dig[4]) begin
                        o_push       = 1'b1;
                        o_grp.status = ST_BAD;
                    end else if (hex_full && !(r_mode == MODE_HEX_FIRST && is_hi)) begin
                        o_push = 1'b1;
                        if (r_mode == MODE_HEX_FIRST ? is_lo : !is_lo) begin
                            o_grp.status = ST_BAD;
                        end else begin
                            o_grp.bytes    = u_bytes;
                            o_grp.last_idx = u_last;
                        end
                    end
                end
                MODE_LOW_BSL: begin
                    o_push       = (i_data_byte != CH_BSL);
                    o_grp.status = ST_BAD;
                end
                MODE_LOW_U: begin
                    o_push       = (i_data_byte != CH_U);
                    o_grp.status = ST_BAD;
                end
                default: begin
                    o_push       = (i_data_byte != CH_QUOTE);
                    o_grp.status = ST_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_hex  <= '0;
            r_cu   <= '0;
            r_hs   <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cu   <= n_cu;
            r_hs   <= n_hs;
        end
    end

endmodule
